// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge, masked while reset is asserted.
`define ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ----- hdl/cdq_pkg.sv -----
// Shared constants, codes and command/status types of the circular deque.
package cdq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int OUT_LIMIT = 64;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_N     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic                capture;   // latch the input beat
        logic                push;      // write ring, bump pointers
        logic                pop;       // read ring, drop pointers
        logic                rd_start;  // first read of a read-out run
        logic                rd_next;   // next read of a read-out run
        logic                emit_stat; // load a status-only result
        logic [STATUS_W-1:0] stat_code;
        logic                emit_data; // load a result from ring read data
    } cdq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            n_zero;    // read-out run has no results
        logic            last_one;  // result being loaded is the final one
        logic            out_free;  // output register can take a result
    } cdq_stat_t;

endpackage

// ----- hdl/cdq_ctrl.sv -----
// Sequencing state machine of the circular deque.
`include "assert_macros.svh"
module cdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  cmd
);
    import cdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_stat = 1'b1;
                            cmd.stat_code = stat.full ? ST_FULL : ST_OK;
                            cmd.push      = !stat.full;
                            state_next    = S_IDLE;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK, OP_READ_ALL, OP_READ_N:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit_stat = 1'b1;
                                cmd.stat_code = ST_EMPTY;
                                state_next    = S_IDLE;
                            end
                        end
                        else if (stat.op == OP_POP_FRONT || stat.op == OP_POP_BACK)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_LOAD;
                        end
                        else if (stat.n_zero)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_LOAD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;   // unused op codes: dropped
                    end
                endcase
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (stat.last_one)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_RST(a_one_emit, clk, rst_n, !(cmd.emit_stat && cmd.emit_data), "two results at once")
    `ASSERT_RST(a_next_with_emit, clk, rst_n, cmd.rd_next |-> cmd.emit_data, "read ran ahead")
    `ASSERT_RST(a_idle_quiet, clk, rst_n, s_tready |-> !(cmd.push || cmd.pop || cmd.emit_data), "work while idle")

endmodule

// ----- hdl/cdq_datapath.sv -----
// Ring memory, pointers, operand latch and output register of the deque.
`include "assert_macros.svh"
module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [cdq_pkg::S_USER_W-1:0]  s_tuser,
    input  cdq_pkg::cdq_cmd_t             cmd,
    output cdq_pkg::cdq_stat_t            stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [cdq_pkg::M_USER_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int N_W   = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] DEPTH_O  = OCC_W'(DEPTH);
    localparam logic [N_W-1:0]   LIMIT_N  = N_W'(OUT_LIMIT);

    // front + offset modulo DEPTH; both operands below DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                  logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    // latched operation
    logic [OP_W-1:0]    op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [COUNT_W-1:0] count_reg;

    // deque state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [OCC_W-1:0] occ_reg, occ_next;

    // read-out walker
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [OCC_W-1:0]   off_reg, off_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;

    // ring memory
    logic [VALUE_W-1:0] ring_reg [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_entry_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic [IDX_W-1:0] front_dec, front_inc, back_slot, back_last;
    logic [OCC_W-1:0] occ_m1;
    logic [IDX_W-1:0] walk_slot;
    logic [OCC_W-1:0] walk_off;
    logic [IDX_W-1:0] adv_slot;
    logic [OCC_W-1:0] adv_off;
    logic [N_W-1:0]   n_sel;
    logic [COUNT_W-1:0] n_sat;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] waddr, raddr;
    logic             out_free;

    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign occ_m1    = occ_reg - 1'b1;
    assign back_slot = wrap_add(front_reg, occ_reg[IDX_W-1:0]);
    assign back_last = wrap_add(front_reg, occ_m1[IDX_W-1:0]);

    // walker advance: wraps to the front after the back entry
    assign walk_slot = cmd.rd_start ? front_reg : slot_reg;
    assign walk_off  = cmd.rd_start ? '0 : off_reg;
    always_comb
    begin
        adv_off  = walk_off + 1'b1;
        adv_slot = (walk_slot == LAST_IDX) ? '0 : walk_slot + 1'b1;
        if (adv_off == occ_reg)
        begin
            adv_off  = '0;
            adv_slot = front_reg;
        end
    end

    assign n_sel = (op_reg == OP_READ_ALL) ? N_W'(occ_reg) : N_W'(count_reg);
    assign n_sat = (n_sel > LIMIT_N) ? COUNT_W'(OUT_LIMIT) : n_sel[COUNT_W-1:0];

    assign mem_we = cmd.push;
    assign waddr  = (op_reg == OP_PUSH_FRONT) ? front_dec : back_slot;
    assign mem_re = cmd.pop || cmd.rd_start || cmd.rd_next;
    always_comb
    begin
        priority if (cmd.pop)
        begin
            raddr = (op_reg == OP_POP_FRONT) ? front_reg : back_last;
        end
        else if (cmd.rd_start)
        begin
            raddr = front_reg;
        end
        else
        begin
            raddr = slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_reg[waddr] <= value_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= ring_reg[raddr];
        end
    end

    // pointer and walker updates
    always_comb
    begin
        front_next  = front_reg;
        occ_next    = occ_reg;
        slot_next   = slot_reg;
        off_next    = off_reg;
        remain_next = remain_reg;
        if (cmd.push)
        begin
            occ_next = occ_reg + 1'b1;
            if (op_reg == OP_PUSH_FRONT)
            begin
                front_next = front_dec;
            end
        end
        if (cmd.pop)
        begin
            occ_next    = occ_m1;
            remain_next = COUNT_W'(1);
            if (op_reg == OP_POP_FRONT)
            begin
                front_next = front_inc;
            end
        end
        if (cmd.rd_start)
        begin
            remain_next = n_sat;
        end
        if (cmd.rd_start || cmd.rd_next)
        begin
            slot_next = adv_slot;
            off_next  = adv_off;
        end
        if (cmd.emit_data)
        begin
            remain_next = remain_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            occ_reg    <= '0;
            slot_reg   <= '0;
            off_reg    <= '0;
            remain_reg <= '0;
        end
        else
        begin
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            slot_reg   <= slot_next;
            off_reg    <= off_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= s_tuser[OP_W-1:0];
            value_reg <= s_tdata[VALUE_W-1:0];
            count_reg <= s_tdata[VALUE_W +: COUNT_W];
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_stat || cmd.emit_data)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_stat)
        begin
            out_entry_reg  <= '0;
            out_status_reg <= cmd.stat_code;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_data)
        begin
            out_entry_reg  <= rdata_reg;
            out_status_reg <= ST_OK;
            out_last_reg   <= (remain_reg == COUNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_entry_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.op       = op_reg;
    assign stat.empty    = (occ_reg == '0);
    assign stat.full     = (occ_reg == DEPTH_O);
    assign stat.n_zero   = (n_sat == '0);
    assign stat.last_one = (remain_reg == COUNT_W'(1));
    assign stat.out_free = out_free;

    `ASSERT_RST(a_occ_bound, clk, rst_n, occ_reg <= DEPTH_O, "occupancy above depth")
    `ASSERT_RST(a_push_room, clk, rst_n, cmd.push |-> (occ_reg != DEPTH_O), "push into full ring")
    `ASSERT_RST(a_emit_free, clk, rst_n, (cmd.emit_stat || cmd.emit_data) |-> out_free, "result overwritten")

endmodule

// ----- hdl/circular_deque_unit.sv -----
// Top level of the circular deque: controller plus ring datapath.
// A push passes IDLE and EXEC before its status is loaded; a pop or read-out adds a ring
// read into registered read data and LOAD, which does one ring read per cycle while the
// output register is free. A new beat is taken in IDLE, after the last result is loaded.
// Reset (rst_n low, asynchronous): queue empty, front index zero, no result pending;
// ring contents are not cleared.
`include "assert_macros.svh"
module circular_deque_unit #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF   // ring slots, 2..1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,  // [31:0] value, [38:32] read_count, pad
    input  logic [cdq_pkg::S_USER_W-1:0]  s_tuser,  // [2:0] op
    // result beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata,  // [31:0] entry
    output logic [cdq_pkg::M_USER_W-1:0]  m_tuser,  // [1:0] status
    output logic                          m_tlast   // final result of the operation
);
    import cdq_pkg::*;

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    // state machine: IDLE takes a beat, EXEC decides, emits a status or pushes or starts a
    // read, LOAD moves ring read data to the output register, one per cycle while it is free
    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring memory, front/occupancy pointers, read walker, output register
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a run of results ends with tlast before the next beat is taken
    `ASSERT_RST(a_no_take_mid_run, clk, rst_n, (s_tready && m_tvalid) |-> m_tlast,
                "beat taken mid-run")
    `ASSERT_RST(a_one_step, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "no beat held")
    `ASSERT_RST(a_status_code, clk, rst_n,
                m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL),
                "bad status code")

endmodule

// ----- bench/tb_circular_deque_unit.sv -----
// Self-checking testbench for circular_deque_unit: directed table, then random stream.
module tb_circular_deque_unit;
    import cdq_pkg::*;

    localparam int TB_DEPTH = DEPTH_DEF;

    // Op codes the block ignores; no package name exists for them.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Sender/receiver idling by phase: 0 = sender 15% / receiver 88%,
    // 1 = sender 88% / receiver 15%, 2 = no random idling on either side.
    localparam int RANDOM_ITEMS   = 260;
    localparam int PHASE1_AT      = 85;
    localparam int PHASE2_AT      = 170;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_REPORTS    = 10;

    // One result beat as the block should produce it.
    typedef struct packed {
        logic [VALUE_W-1:0]  entry;
        logic [STATUS_W-1:0] status;
        logic                last;
    } deque_result_t;

    // Directed stimulus row. Rows with reps above one push fresh random
    // values; typed rows carry their single result written out by hand.
    typedef struct {
        logic [OP_W-1:0]     op;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
        int                  reps;
        bit                  typed;
        logic [VALUE_W-1:0]  entry;
        logic [STATUS_W-1:0] status;
    } stim_row_t;

    localparam int N_ROWS = 26;

    stim_row_t directed_rows [0:N_ROWS-1] = '{
        // empty queue: every pop and read reports empty, whatever the count
        '{OP_POP_FRONT,  32'h0,        7'd0,   1, 1'b1, 32'h0, ST_EMPTY},
        '{OP_POP_BACK,   32'h0,        7'd0,   1, 1'b1, 32'h0, ST_EMPTY},
        '{OP_READ_ALL,   32'h0,        7'd0,   1, 1'b1, 32'h0, ST_EMPTY},
        '{OP_READ_N,     32'h0,        7'd0,   1, 1'b1, 32'h0, ST_EMPTY},
        '{OP_READ_N,     32'h0,        7'd127, 1, 1'b1, 32'h0, ST_EMPTY},
        '{OP_SPARE_6,    32'hFFFFFFFF, 7'd127, 1, 1'b0, 32'h0, ST_OK},
        // pushes at both ends with extreme values
        '{OP_PUSH_FRONT, 32'h7FFFFFFF, 7'd0,   1, 1'b1, 32'h0, ST_OK},
        '{OP_PUSH_BACK,  32'h80000000, 7'd0,   1, 1'b1, 32'h0, ST_OK},
        '{OP_PUSH_FRONT, 32'hFFFFFFFF, 7'd127, 1, 1'b1, 32'h0, ST_OK},
        '{OP_PUSH_BACK,  32'h00000000, 7'd0,   1, 1'b1, 32'h0, ST_OK},
        // read-outs: zero count gives nothing, counts past 64 saturate
        '{OP_READ_ALL,   32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK},
        '{OP_READ_N,     32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK},
        '{OP_READ_N,     32'h0,        7'd7,   1, 1'b0, 32'h0, ST_OK},
        '{OP_READ_N,     32'h0,        7'd64,  1, 1'b0, 32'h0, ST_OK},
        '{OP_READ_N,     32'h0,        7'd127, 1, 1'b0, 32'h0, ST_OK},
        '{OP_SPARE_7,    32'hFFFFFFFF, 7'd127, 1, 1'b0, 32'h0, ST_OK},
        '{OP_POP_FRONT,  32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK},
        '{OP_POP_BACK,   32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK},
        // fill to the brim, then both pushes are refused
        '{OP_PUSH_BACK,  32'h0,        7'd0,  30, 1'b0, 32'h0, ST_OK},
        '{OP_PUSH_FRONT, 32'h12345678, 7'd0,   1, 1'b1, 32'h0, ST_FULL},
        '{OP_PUSH_BACK,  32'h12345678, 7'd0,   1, 1'b1, 32'h0, ST_FULL},
        '{OP_READ_ALL,   32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK},
        '{OP_READ_N,     32'h0,        7'd64,  1, 1'b0, 32'h0, ST_OK},
        '{OP_POP_BACK,   32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK},
        '{OP_READ_N,     32'h0,        7'd33,  1, 1'b0, 32'h0, ST_OK},
        '{OP_POP_FRONT,  32'h0,        7'd0,   1, 1'b0, 32'h0, ST_OK}
    };

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    // Mirror of the deque contents, kept in step with accepted beats.
    logic [VALUE_W-1:0] ring_mirror [TB_DEPTH];
    int unsigned        head_slot  = 0;
    int unsigned        fill_level = 0;

    deque_result_t step_results [$];   // results of the latest op
    deque_result_t due_results  [$];   // results still owed by the block

    int  phase      = 0;
    int  fail_count = 0;
    bit  hold_off   = 1'b0;

    circular_deque_unit #(
        .DEPTH(TB_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void queue_result(logic [VALUE_W-1:0] entry,
                                         logic [STATUS_W-1:0] status, logic last);
        deque_result_t res;
        res.entry  = entry;
        res.status = status;
        res.last   = last;
        step_results.push_back(res);
    endfunction

    // Applies one op to the mirror and lists the results it should give.
    function automatic void apply_deque_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                           logic [COUNT_W-1:0] count);
        int unsigned n;
        int unsigned i;
        step_results.delete();
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill_level >= TB_DEPTH)
                    queue_result('0, ST_FULL, 1'b1);
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head_slot = (head_slot + TB_DEPTH - 1) % TB_DEPTH;
                        ring_mirror[head_slot] = value;
                    end
                    else
                        ring_mirror[(head_slot + fill_level) % TB_DEPTH] = value;
                    fill_level++;
                    queue_result('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill_level == 0)
                    queue_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        queue_result(ring_mirror[head_slot], ST_OK, 1'b1);
                        head_slot = (head_slot + 1) % TB_DEPTH;
                    end
                    else
                        queue_result(ring_mirror[(head_slot + fill_level - 1) % TB_DEPTH],
                                     ST_OK, 1'b1);
                    fill_level--;
                end
            end
            OP_READ_ALL, OP_READ_N:
            begin
                if (fill_level == 0)
                    queue_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    n = (op == OP_READ_ALL) ? fill_level : int'(count);
                    if (n > OUT_LIMIT)
                        n = OUT_LIMIT;
                    // read n wraps back to the front after the back entry
                    for (i = 0; i < n; i++)
                        queue_result(ring_mirror[(head_slot + i % fill_level) % TB_DEPTH],
                                     ST_OK, (i + 1 == n));
                end
            end
            default:
            begin
                // spare op codes: no results, no state change
            end
        endcase
    endfunction

    // Offers one beat after a random gap, waits for acceptance, then books
    // the results it owes. Valid stays high across back-to-back beats.
    task automatic send_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                           logic [COUNT_W-1:0] count, bit typed,
                           logic [VALUE_W-1:0] t_entry, logic [STATUS_W-1:0] t_status);
        int            gap_pct;
        deque_result_t res;
        gap_pct = (phase == 0) ? 15 : (phase == 1) ? 88 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, count, value};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_deque_op(op, value, count);
        if (typed)
        begin
            res.entry  = t_entry;
            res.status = t_status;
            res.last   = 1'b1;
            due_results.push_back(res);
        end
        else
            foreach (step_results[k])
                due_results.push_back(step_results[k]);
    endtask

    // Result side: random ready per phase, blocked outright during hold-off.
    // Each accepted beat is checked against the oldest owed result.
    always @(posedge clk)
    begin
        deque_result_t want;
        int            stall_pct;
        stall_pct = (phase == 0) ? 88 : (phase == 1) ? 15 : 0;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat: entry %h status %0d last %0d",
                             m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = due_results.pop_front();
                if (m_tdata !== want.entry || m_tuser !== want.status
                    || m_tlast !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected entry %h status %0d last %0d, got entry %h status %0d last %0d",
                                 want.entry, want.status, want.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Back-pressure: once the no-idle phase starts, refuse results for a
    // long stretch so the output register fills and input ready drops.
    initial
    begin
        wait (phase == 2);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int                 r;
        int                 k;
        int                 counted;
        int                 mode;
        int                 pick;
        int                 push_pct;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < N_ROWS; r++)
            for (k = 0; k < directed_rows[r].reps; k++)
                send_op(directed_rows[r].op,
                        (directed_rows[r].reps > 1) ? $urandom : directed_rows[r].value,
                        directed_rows[r].count, directed_rows[r].typed,
                        directed_rows[r].entry, directed_rows[r].status);

        // Random stream. The push/pop bias is drawn at random every 32 counted beats from
        // balanced, filling and draining, so full and empty are both reached
        // often; reads and spare codes are sprinkled in. Spare codes are not
        // counted since the block ignores them.
        counted = 0;
        mode    = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 32 == 0)
                mode = $urandom_range(2);
            phase = (counted >= PHASE2_AT) ? 2 : (counted >= PHASE1_AT) ? 1 : 0;
            push_pct = (mode == 0) ? 50 : (mode == 1) ? 80 : 20;

            case ($urandom_range(7))
                0: value = 32'h00000000;
                1: value = 32'h7FFFFFFF;
                2: value = 32'h80000000;
                3: value = 32'hFFFFFFFF;
                default: value = $urandom;
            endcase
            case ($urandom_range(5))
                0: count = COUNT_W'($urandom_range(65, 127));
                1: count = $urandom_range(1) ? 7'd64 : 7'd0;
                default: count = COUNT_W'($urandom_range(1, 40));
            endcase

            pick = $urandom_range(99);
            if (pick < 4)
                op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
            else if (pick < 14)
                op = $urandom_range(1) ? OP_READ_ALL : OP_READ_N;
            else if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;

            send_op(op, value, count, 1'b0, '0, ST_OK);
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                counted++;
        end
        s_tvalid <= 1'b0;

        // drain everything owed, then let the block settle
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
